### hw/rtl/led_frame_store_serial_shift_out_top_defines.svh
// Assertion macros for the LED frame store.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef LED_FRAME_STORE_SERIAL_SHIFT_OUT_TOP_DEFINES_SVH
`define LED_FRAME_STORE_SERIAL_SHIFT_OUT_TOP_DEFINES_SVH

// Clocked property, off while reset is asserted
`define LFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication
`define LFS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	`LFS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### hw/rtl/lfs_pkg.sv
// Shared types and constants for the LED frame store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

	localparam int LED_COUNT_DEF    = 12;
	localparam int CHANNEL_BITS_DEF = 12;

	localparam int CMD_W    = 2;
	localparam int LED_IN_W = 4;
	localparam int COLOR_W  = 8;
	localparam int CH_W     = 6;
	localparam int GAP_W    = 8;
	localparam int BIT_W    = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 8;

	// LED number that moves to the far end of the string
	localparam int REMAP_LED = 6;

	localparam logic [CH_W-1:0]  GAP_AFTER_RST  = CH_W'(18);
	localparam logic [GAP_W-1:0] GAP_CLOCKS_RST = GAP_W'(72);

	localparam logic [CFG_IDX_W-1:0] CFG_GAP_AFTER  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_CLOCKS = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_START = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_SHIFT = 2'd1,
		PH_GAP   = 2'd2,
		PH_LATCH = 2'd3
	} phase_t;

	// Slot order inside one LED row of the store
	typedef enum logic [1:0] {
		SLOT_RED   = 2'd0,
		SLOT_BLUE  = 2'd1,
		SLOT_GREEN = 2'd2
	} slot_t;

	typedef struct packed {
		logic             capture;
		logic             load;
		logic             sel_bit;
		logic [BIT_W-1:0] bit_idx;
		logic             clock_pulse;
		logic             latch_pulse;
		logic             rd_en;
		logic             wr_en;
		logic             busy;
		logic             ch_start;
		logic             ch_dec;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/lfs_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on lfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lfs_item_if import lfs_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [LED_IN_W-1:0] led;
	logic [COLOR_W-1:0]  red;
	logic [COLOR_W-1:0]  green;
	logic [COLOR_W-1:0]  blue;

	modport source (output valid, cmd, led, red, green, blue, input ready);
	modport sink   (input valid, cmd, led, red, green, blue, output ready);
endinterface

interface lfs_result_if import lfs_pkg::*;;
	logic               valid;
	logic               ready;
	logic               data_bit;
	logic               clock_pulse;
	logic               latch_pulse;
	logic [COLOR_W-1:0] read_red;
	logic [COLOR_W-1:0] read_green;
	logic [COLOR_W-1:0] read_blue;
	logic               busy_res;

	modport source (output valid, data_bit, clock_pulse, latch_pulse,
		read_red, read_green, read_blue, busy_res, input ready);
	modport sink   (input valid, data_bit, clock_pulse, latch_pulse,
		read_red, read_green, read_blue, busy_res, output ready);
endinterface

`default_nettype wire

### hw/rtl/lfs_ctrl.sv
// Frame sequencer: phase FSM, bit/channel/gap counters, handshake and config.
// Depends on lfs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "led_frame_store_serial_shift_out_top_defines.svh"

module lfs_ctrl import lfs_pkg::*; #(
	parameter int LED_COUNT    = LED_COUNT_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	input  wire logic [CMD_W-1:0]     item_cmd,
	output logic                      item_ready,
	input  wire logic                 result_ready,
	output logic                      result_valid,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	output ctrl_cmd_t                 ctl
);

	localparam int NUM_CH = LED_COUNT * 3;

	phase_t             phase_q, phase_d;
	cmd_t               cmd_q;
	logic [CH_W-1:0]    ch_q, ch_d;
	logic [BIT_W-1:0]   bit_q, bit_d;
	logic [GAP_W-1:0]   gap_q, gap_d;
	logic [CH_W-1:0]    gap_after_q;
	logic [GAP_W-1:0]   gap_clocks_q;
	logic               work_q;
	logic               result_valid_q;
	logic               accept;
	logic               step;
	logic               adv;

	assign item_ready   = !work_q;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_after_q  <= GAP_AFTER_RST;
			gap_clocks_q <= GAP_CLOCKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAP_AFTER:  gap_after_q  <= cfg_wdata[CH_W-1:0];
				CFG_GAP_CLOCKS: gap_clocks_q <= cfg_wdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			ch_q           <= '0;
			bit_q          <= '0;
			gap_q          <= '0;
			work_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			ch_q    <= ch_d;
			bit_q   <= bit_d;
			gap_q   <= gap_d;
			if (accept) begin
				work_q <= 1'b1;
			end else if (step) begin
				work_q <= 1'b0;
			end
			if (step) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(item_cmd);
		end
	end

	always_comb begin
		phase_d = phase_q;
		ch_d    = ch_q;
		bit_d   = bit_q;
		gap_d   = gap_q;
		adv     = 1'b0;
		ctl     = '0;
		accept  = item_valid && !work_q;
		step    = work_q && (!result_valid_q || result_ready);
		ctl.capture = accept;
		ctl.load    = step;
		ctl.bit_idx = bit_q;
		if (step) begin
			if (cmd_q == CMD_TICK) begin
				case (phase_q)
					PH_SHIFT: begin
						ctl.sel_bit     = 1'b1;
						ctl.clock_pulse = 1'b1;
						if (bit_q != '0) begin
							bit_d = bit_q - BIT_W'(1);
						end else if (ch_q == gap_after_q && gap_clocks_q != '0) begin
							gap_d   = gap_clocks_q;
							phase_d = PH_GAP;
						end else begin
							adv = 1'b1;
						end
					end
					PH_GAP: begin
						ctl.clock_pulse = 1'b1;
						gap_d = gap_q - GAP_W'(1);
						if (gap_q == GAP_W'(1)) begin
							adv = 1'b1;
						end
					end
					PH_LATCH: begin
						ctl.latch_pulse = 1'b1;
						phase_d = PH_IDLE;
					end
					default: ;
				endcase
			end else if (phase_q == PH_IDLE) begin
				case (cmd_q)
					CMD_WRITE: ctl.wr_en = 1'b1;
					CMD_READ:  ctl.rd_en = 1'b1;
					CMD_START: begin
						ch_d         = CH_W'(NUM_CH - 1);
						bit_d        = BIT_W'(CHANNEL_BITS - 1);
						gap_d        = '0;
						phase_d      = PH_SHIFT;
						ctl.ch_start = 1'b1;
					end
					default: ;
				endcase
			end
		end
		// end of a channel: next one down, or latch after channel zero
		if (adv) begin
			if (ch_q == '0) begin
				phase_d = PH_LATCH;
			end else begin
				ch_d       = ch_q - CH_W'(1);
				bit_d      = BIT_W'(CHANNEL_BITS - 1);
				phase_d    = PH_SHIFT;
				ctl.ch_dec = 1'b1;
			end
		end
		ctl.busy = (phase_d != PH_IDLE);
	end

	`LFS_ASSERT_IMPLY(a_bit_range, phase_q == PH_SHIFT, bit_q <= BIT_W'(CHANNEL_BITS - 1),
		"bit counter beyond channel width")
	`LFS_ASSERT_IMPLY(a_ch_range, phase_q != PH_IDLE, ch_q < CH_W'(NUM_CH),
		"channel index beyond store")
	`LFS_ASSERT_IMPLY(a_gap_nonzero, phase_q == PH_GAP, gap_q != '0,
		"gap phase with empty gap counter")
	`LFS_ASSERT_IMPLY(a_latch_last, phase_q == PH_LATCH, ch_q == '0,
		"latch reached before channel zero")

endmodule

`default_nettype wire

### hw/rtl/lfs_datapath.sv
// Color store, channel row/slot tracking and result register.
// Depends on lfs_pkg; driven by ctrl_cmd_t from lfs_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module lfs_datapath import lfs_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctrl_cmd_t           ctl,
	input  wire logic [CMD_W-1:0]    item_cmd,
	input  wire logic [LED_IN_W-1:0] item_led,
	input  wire logic [COLOR_W-1:0]  item_red,
	input  wire logic [COLOR_W-1:0]  item_green,
	input  wire logic [COLOR_W-1:0]  item_blue,
	output logic                     data_bit,
	output logic                     clock_pulse,
	output logic                     latch_pulse,
	output logic [COLOR_W-1:0]       read_red,
	output logic [COLOR_W-1:0]       read_green,
	output logic [COLOR_W-1:0]       read_blue,
	output logic                     busy_res
);

	localparam int LED_W = $clog2(LED_COUNT);
	localparam int RW    = LED_W + 1;
	localparam int ROW_W = 3 * COLOR_W;

	// one row per LED: {red, blue, green}
	logic [ROW_W-1:0]     color_mem [LED_COUNT];
	logic [LED_COUNT-1:0] row_valid_q;

	logic [RW-1:0]      led_x;
	logic [RW-1:0]      remap;
	logic               in_range;
	logic [LED_W-1:0]   rd_addr;
	logic [LED_W-1:0]   addr_q;
	logic               in_range_q;
	logic [COLOR_W-1:0] red_q, green_q, blue_q;
	logic [ROW_W-1:0]   rd_data_q;
	logic               rd_valid_q;
	logic [ROW_W-1:0]   rd_row;
	logic [LED_W-1:0]   row_q;
	slot_t              slot_q;
	logic [COLOR_W-1:0] chan_val;
	logic [15:0]        chan_word;

	logic               data_bit_q, clock_pulse_q, latch_pulse_q, busy_q;
	logic [COLOR_W-1:0] read_red_q, read_green_q, read_blue_q;

	always_comb begin
		led_x = RW'(item_led);
		if (led_x == RW'(REMAP_LED)) begin
			remap = RW'(LED_COUNT - 1);
		end else if (led_x > RW'(REMAP_LED)) begin
			remap = led_x - RW'(1);
		end else begin
			remap = led_x;
		end
		in_range = remap < RW'(LED_COUNT);
		if (item_cmd == CMD_TICK) begin
			rd_addr = row_q;
		end else if (in_range) begin
			rd_addr = remap[LED_W-1:0];
		end else begin
			rd_addr = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			rd_data_q  <= color_mem[rd_addr];
			addr_q     <= rd_addr;
			in_range_q <= in_range;
			red_q      <= item_red;
			green_q    <= item_green;
			blue_q     <= item_blue;
		end
		if (ctl.load && ctl.wr_en && in_range_q) begin
			color_mem[addr_q] <= {red_q, blue_q, green_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
			row_q       <= '0;
			slot_q      <= SLOT_RED;
		end else begin
			if (ctl.capture) begin
				rd_valid_q <= row_valid_q[rd_addr];
			end
			if (ctl.load && ctl.wr_en && in_range_q) begin
				row_valid_q[addr_q] <= 1'b1;
			end
			if (ctl.ch_start) begin
				row_q  <= LED_W'(LED_COUNT - 1);
				slot_q <= SLOT_GREEN;
			end else if (ctl.ch_dec) begin
				case (slot_q)
					SLOT_RED: begin
						slot_q <= SLOT_GREEN;
						row_q  <= row_q - LED_W'(1);
					end
					SLOT_BLUE:  slot_q <= SLOT_RED;
					SLOT_GREEN: slot_q <= SLOT_BLUE;
					default:    slot_q <= SLOT_RED;
				endcase
			end
		end
	end

	// never-written rows read as zero
	assign rd_row = rd_valid_q ? rd_data_q : '0;

	always_comb begin
		case (slot_q)
			SLOT_RED:   chan_val = rd_row[3*COLOR_W-1:2*COLOR_W];
			SLOT_BLUE:  chan_val = rd_row[2*COLOR_W-1:COLOR_W];
			SLOT_GREEN: chan_val = rd_row[COLOR_W-1:0];
			default:    chan_val = '0;
		endcase
		// value times 16; bit index always stays below the channel width
		chan_word = {4'b0000, chan_val, 4'b0000};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_bit_q    <= ctl.sel_bit && chan_word[ctl.bit_idx];
			clock_pulse_q <= ctl.clock_pulse;
			latch_pulse_q <= ctl.latch_pulse;
			busy_q        <= ctl.busy;
			if (ctl.rd_en && in_range_q) begin
				read_red_q   <= rd_row[3*COLOR_W-1:2*COLOR_W];
				read_blue_q  <= rd_row[2*COLOR_W-1:COLOR_W];
				read_green_q <= rd_row[COLOR_W-1:0];
			end else begin
				read_red_q   <= '0;
				read_blue_q  <= '0;
				read_green_q <= '0;
			end
		end
	end

	assign data_bit    = data_bit_q;
	assign clock_pulse = clock_pulse_q;
	assign latch_pulse = latch_pulse_q;
	assign read_red    = read_red_q;
	assign read_green  = read_green_q;
	assign read_blue   = read_blue_q;
	assign busy_res    = busy_q;

endmodule

`default_nettype wire

### hw/rtl/led_frame_store_serial_shift_out_top.sv
// Channel    Dir  Beat content
// item       in   cmd, led, red, green, blue
// result     out  data_bit, clock_pulse, latch_pulse, read_red/green/blue, busy_res
// cfg        in   cfg_we, cfg_index, cfg_wdata (write only)
//
// The accept edge registers the color store read; once the result register is free
// or taken, a later edge advances the sequencer and loads the result register.
// A new beat is taken once the previous item has left the work stage.
// A stalled result holds the item in the work stage; the next beat waits.
// Reset clears the row valid bits at once, so no clearing pass is needed.
// Depends on lfs_pkg, lfs_if, lfs_ctrl and lfs_datapath.
`timescale 1ns / 1ps
`default_nettype none

module led_frame_store_serial_shift_out_top import lfs_pkg::*; #(
	parameter int LED_COUNT    = LED_COUNT_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	lfs_item_if.sink                  item,
	lfs_result_if.source              result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	ctrl_cmd_t ctl;
	logic      item_ready;
	logic      result_valid;

	assign item.ready   = item_ready;
	assign result.valid = result_valid;

	lfs_ctrl #(
		.LED_COUNT    (LED_COUNT),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_cmd     (item.cmd),
		.item_ready   (item_ready),
		.result_ready (result.ready),
		.result_valid (result_valid),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.ctl          (ctl)
	);

	lfs_datapath #(
		.LED_COUNT (LED_COUNT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.item_cmd    (item.cmd),
		.item_led    (item.led),
		.item_red    (item.red),
		.item_green  (item.green),
		.item_blue   (item.blue),
		.data_bit    (result.data_bit),
		.clock_pulse (result.clock_pulse),
		.latch_pulse (result.latch_pulse),
		.read_red    (result.read_red),
		.read_green  (result.read_green),
		.read_blue   (result.read_blue),
		.busy_res    (result.busy_res)
	);

endmodule

`default_nettype wire

### sim/led_frame_store_serial_shift_out_top_test.sv
// Self-checking bench for the LED frame store: color writes/reads, frame shift-out
// with gap and latch, checked beat by beat against an in-bench predictor.
// Depends on lfs_pkg, lfs_if and led_frame_store_serial_shift_out_top.
`timescale 1ns / 1ps

module led_frame_store_serial_shift_out_top_test import lfs_pkg::*;;

	localparam int NUM_CH          = LED_COUNT_DEF * 3;
	localparam int ITEM_BUDGET     = 1100;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int DRAIN_CYCLES    = 4;
	localparam int END_CYCLES      = 8;

	typedef struct packed {
		cmd_t                cmd;
		logic [LED_IN_W-1:0] led;
		logic [COLOR_W-1:0]  red;
		logic [COLOR_W-1:0]  green;
		logic [COLOR_W-1:0]  blue;
	} cmd_beat_t;

	typedef struct packed {
		logic               data_bit;
		logic               clock_pulse;
		logic               latch_pulse;
		logic [COLOR_W-1:0] read_red;
		logic [COLOR_W-1:0] read_green;
		logic [COLOR_W-1:0] read_blue;
		logic               busy_res;
	} out_beat_t;

	class shift_out_checker;
		logic [COLOR_W-1:0] colors [NUM_CH];
		logic [CH_W-1:0]    chan;
		logic [BIT_W-1:0]   bit_cnt;
		logic [GAP_W-1:0]   gap_cnt;
		phase_t             phase;
		logic [CH_W-1:0]    gap_after;
		logic [GAP_W-1:0]   gap_len;
		out_beat_t          pending_outputs [$];
		int                 errors;

		function new();
			foreach (colors[i]) colors[i] = '0;
			chan = '0;
			bit_cnt = '0;
			gap_cnt = '0;
			phase = PH_IDLE;
			gap_after = GAP_AFTER_RST;
			gap_len = GAP_CLOCKS_RST;
			errors = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == CFG_GAP_AFTER) begin
				gap_after = val[CH_W-1:0];
			end else begin
				gap_len = val[GAP_W-1:0];
			end
		endfunction

		function bit frame_running();
			return phase != PH_IDLE;
		endfunction

		function int pending_count();
			return pending_outputs.size();
		endfunction

		function void next_channel();
			if (chan == '0) begin
				phase = PH_LATCH;
			end else begin
				chan = chan - CH_W'(1);
				bit_cnt = BIT_W'(CHANNEL_BITS_DEF - 1);
				phase = PH_SHIFT;
			end
		endfunction

		// Advances the frame state by one accepted command and queues its output beat
		function void note_command(cmd_beat_t c);
			out_beat_t   o;
			int          led_no;
			int          base;
			logic [31:0] word;
			o = '0;
			if (c.cmd == CMD_TICK) begin
				case (phase)
					PH_SHIFT: begin
						word = '0;
						if (int'(chan) < NUM_CH)
							word = (32'(colors[chan]) << 4) & ((32'd1 << CHANNEL_BITS_DEF) - 1);
						o.data_bit = word[bit_cnt];
						o.clock_pulse = 1'b1;
						if (bit_cnt != '0) begin
							bit_cnt = bit_cnt - BIT_W'(1);
						end else if (chan == gap_after && gap_len != '0) begin
							gap_cnt = gap_len;
							phase = PH_GAP;
						end else begin
							next_channel();
						end
					end
					PH_GAP: begin
						o.clock_pulse = 1'b1;
						gap_cnt = gap_cnt - GAP_W'(1);
						if (gap_cnt == '0)
							next_channel();
					end
					PH_LATCH: begin
						o.latch_pulse = 1'b1;
						phase = PH_IDLE;
					end
					default: ;
				endcase
			end else if (phase == PH_IDLE) begin
				led_no = int'(c.led);
				if (led_no == REMAP_LED)
					led_no = LED_COUNT_DEF - 1;
				else if (led_no > REMAP_LED)
					led_no = led_no - 1;
				base = led_no * 3;
				case (c.cmd)
					CMD_WRITE: begin
						if (led_no < LED_COUNT_DEF) begin
							colors[base + int'(SLOT_RED)] = c.red;
							colors[base + int'(SLOT_BLUE)] = c.blue;
							colors[base + int'(SLOT_GREEN)] = c.green;
						end
					end
					CMD_READ: begin
						if (led_no < LED_COUNT_DEF) begin
							o.read_red = colors[base + int'(SLOT_RED)];
							o.read_green = colors[base + int'(SLOT_GREEN)];
							o.read_blue = colors[base + int'(SLOT_BLUE)];
						end
					end
					default: begin
						chan = CH_W'(NUM_CH - 1);
						bit_cnt = BIT_W'(CHANNEL_BITS_DEF - 1);
						gap_cnt = '0;
						phase = PH_SHIFT;
					end
				endcase
			end
			o.busy_res = (phase != PH_IDLE);
			pending_outputs.push_back(o);
		endfunction

		task report(string msg);
			errors++;
			$display("%0t MISMATCH %s", $realtime, msg);
		endtask

		task compare_field(string name, int got, int want);
			if (got != want)
				report($sformatf("%s: got %0d, want %0d", name, got, want));
		endtask

		task check_output(out_beat_t got);
			out_beat_t want;
			if (pending_outputs.size() == 0) begin
				report("output beat with no command waiting");
			end else begin
				want = pending_outputs.pop_front();
				compare_field("data_bit", got.data_bit, want.data_bit);
				compare_field("clock_pulse", got.clock_pulse, want.clock_pulse);
				compare_field("latch_pulse", got.latch_pulse, want.latch_pulse);
				compare_field("read_red", got.read_red, want.read_red);
				compare_field("read_green", got.read_green, want.read_green);
				compare_field("read_blue", got.read_blue, want.read_blue);
				compare_field("busy_res", got.busy_res, want.busy_res);
			end
		endtask

		task finish_check();
			if (pending_outputs.size() != 0)
				report($sformatf("%0d output beats never arrived", pending_outputs.size()));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	lfs_item_if   item_ch ();
	lfs_result_if result_ch ();

	shift_out_checker frame_chk;
	cmd_beat_t        seen_cmd;
	out_beat_t        seen_out;
	bit               rx_hold;
	int               tx_calm;
	int               rx_calm;
	int               idle_cycles;
	int               sent_items;

	led_frame_store_serial_shift_out_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones, and now and then a calm stretch with none
	function automatic int pick_gap(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(99) < 2) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Returns at the falling edge after the accepting edge, with valid still high
	task automatic send_cmd(cmd_t op, logic [LED_IN_W-1:0] led, logic [COLOR_W-1:0] r,
			logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
		int gap;
		gap = pick_gap(tx_calm);
		sent_items++;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= op;
		item_ch.led <= led;
		item_ch.red <= r;
		item_ch.green <= g;
		item_ch.blue <= b;
		do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
		@(negedge clk);
	endtask

	task automatic send_random(cmd_t op);
		send_cmd(op, LED_IN_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 255)),
			COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)));
	endtask

	// Called at a falling edge; drops valid and waits out every pending output beat
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (frame_chk.pending_count() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		frame_chk.set_register(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Ticks until the frame latches, with some commands that a busy block must ignore
	task automatic finish_frame();
		int r;
		while (frame_chk.frame_running()) begin
			r = $urandom_range(299);
			if (r == 0)
				wait_drained();
			if (r < 18)
				send_random(cmd_t'($urandom_range(0, 2)));
			else
				send_random(CMD_TICK);
		end
	endtask

	initial begin
		result_ch.ready = 1'b0;
		rx_calm = 0;
		forever begin : rx_loop
			int stall;
			@(negedge clk);
			if (rx_hold) begin
				rx_hold = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end else if (stall > 0) begin
				stall--;
			end else begin
				stall = pick_gap(rx_calm);
			end
			result_ch.ready <= (stall == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				seen_cmd.cmd = cmd_t'(item_ch.cmd);
				seen_cmd.led = item_ch.led;
				seen_cmd.red = item_ch.red;
				seen_cmd.green = item_ch.green;
				seen_cmd.blue = item_ch.blue;
				frame_chk.note_command(seen_cmd);
			end
			if (result_ch.valid && result_ch.ready) begin
				seen_out.data_bit = result_ch.data_bit;
				seen_out.clock_pulse = result_ch.clock_pulse;
				seen_out.latch_pulse = result_ch.latch_pulse;
				seen_out.read_red = result_ch.read_red;
				seen_out.read_green = result_ch.read_green;
				seen_out.read_blue = result_ch.read_blue;
				seen_out.busy_res = result_ch.busy_res;
				frame_chk.check_output(seen_out);
			end
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int                 phase_no;
		int                 r;
		logic [CFG_W-1:0]   gap_after_val;
		logic [CFG_W-1:0]   gap_clocks_val;
		frame_chk = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_TICK;
		item_ch.led = '0;
		item_ch.red = '0;
		item_ch.green = '0;
		item_ch.blue = '0;
		rx_hold = 1'b0;
		tx_calm = 0;
		idle_cycles = 0;
		sent_items = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: remap corners, slot order, out-of-range numbers, idle tick,
		// commands while busy, one frame at the reset register values.
		send_cmd(CMD_READ, 4'd0, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_WRITE, 4'd0, 8'hFF, 8'h00, 8'h01);
		send_cmd(CMD_WRITE, 4'd6, 8'h00, 8'hFF, 8'h80);
		send_cmd(CMD_WRITE, 4'd5, 8'h12, 8'h34, 8'h56);
		send_cmd(CMD_WRITE, 4'd7, 8'hA5, 8'h5A, 8'hC3);
		send_cmd(CMD_WRITE, 4'd15, 8'h77, 8'h77, 8'h77);
		send_cmd(CMD_READ, 4'd6, 8'hFF, 8'hFF, 8'hFF);
		send_cmd(CMD_READ, 4'd0, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_WRITE, 4'd12, 8'h55, 8'hAA, 8'h0F);
		send_cmd(CMD_READ, 4'd6, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_READ, 4'd7, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_READ, 4'd13, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_READ, 4'd15, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_WRITE, 4'd11, 8'hFF, 8'hFF, 8'hFF);
		send_cmd(CMD_TICK, 4'd3, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_START, 4'd0, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_WRITE, 4'd0, 8'h11, 8'h22, 8'h33);
		send_cmd(CMD_READ, 4'd0, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_START, 4'd0, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_TICK, 4'd0, 8'h00, 8'h00, 8'h00);
		finish_frame();
		send_cmd(CMD_TICK, 4'd0, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_READ, 4'd0, 8'h00, 8'h00, 8'h00);

		phase_no = 0;
		while (sent_items < ITEM_BUDGET) begin
			wait_drained();
			case (phase_no)
				0: begin
					gap_after_val = 8'd0;
					gap_clocks_val = 8'd255;
				end
				1: begin
					gap_after_val = 8'hFF;
					gap_clocks_val = 8'd7;
				end
				2: begin
					gap_after_val = 8'd35;
					gap_clocks_val = 8'd0;
				end
				default: begin
					gap_after_val = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(0, 255)) :
						CFG_W'($urandom_range(0, NUM_CH - 1));
					r = $urandom_range(99);
					gap_clocks_val = (r < 10) ? 8'd0 : (r < 18) ? 8'd255 :
						CFG_W'($urandom_range(1, 24));
				end
			endcase
			write_reg(CFG_GAP_AFTER, gap_after_val);
			write_reg(CFG_GAP_CLOCKS, gap_clocks_val);
			repeat ($urandom_range(3, 25)) begin
				r = $urandom_range(99);
				if (r < 45)
					send_random(CMD_WRITE);
				else if (r < 85)
					send_random(CMD_READ);
				else
					send_random(CMD_TICK);
			end
			if (phase_no < 3 || $urandom_range(2) != 0) begin
				send_random(CMD_START);
				// first frame: output side stalls long enough to back up the input
				if (phase_no == 0)
					rx_hold = 1'b1;
				finish_frame();
			end
			phase_no++;
		end

		wait_drained();
		repeat (END_CYCLES) @(negedge clk);
		frame_chk.finish_check();
		if (frame_chk.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/lfs_pkg.sv
hw/rtl/lfs_if.sv
hw/rtl/lfs_ctrl.sv
hw/rtl/lfs_datapath.sv
hw/rtl/led_frame_store_serial_shift_out_top.sv
sim/led_frame_store_serial_shift_out_top_test.sv
